// ===== hw/rtl/ppurwq_pkg.sv =====
// shared types and constants for the video register write queue
package ppurwq_pkg;

  localparam int unsigned QueueEntriesDef = 32;

  localparam int unsigned AddrW = 14;
  localparam int unsigned DataW = 8;

  // request kinds
  localparam logic ReqWrite = 1'b0;
  localparam logic ReqFlush = 1'b1;

  // register indexes; 2, 3 and 4 are ignored
  localparam logic [2:0] RegCtrl   = 3'd0;
  localparam logic [2:0] RegMask   = 3'd1;
  localparam logic [2:0] RegScroll = 3'd5;
  localparam logic [2:0] RegAddr   = 3'd6;
  localparam logic [2:0] RegData   = 3'd7;

  localparam logic [DataW-1:0] CtrlForceMask = 8'h80;
  localparam int unsigned      CtrlIncBit    = 2;
  localparam logic [AddrW-1:0] AddrIncRow    = 14'd32;
  localparam logic [AddrW-1:0] AddrIncOne    = 14'd1;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
  } entry_t;

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StLoad,
    StEmpty
  } state_e;

endpackage

// ===== hw/rtl/ppurwq_req_if.sv =====
// request channel: register writes and frame flushes
interface ppurwq_req_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [2:0]                    reg_index;
  logic [ppurwq_pkg::DataW-1:0]  data_value;

  modport source (
    output valid, req_type, reg_index, data_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, reg_index, data_value,
    output ready
  );
endinterface

// ===== hw/rtl/ppurwq_rsp_if.sv =====
// result channel: drained queue entries with shadow register values
interface ppurwq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ppurwq_pkg::DataW-1:0]  ctrl_out;
  logic [ppurwq_pkg::DataW-1:0]  mask_out;
  logic [ppurwq_pkg::DataW-1:0]  scroll_x;
  logic [ppurwq_pkg::DataW-1:0]  scroll_y;
  logic                          entry_valid;
  logic [ppurwq_pkg::AddrW-1:0]  entry_addr;
  logic [ppurwq_pkg::DataW-1:0]  entry_data;
  logic                          last;

  modport source (
    output valid, ctrl_out, mask_out, scroll_x, scroll_y,
           entry_valid, entry_addr, entry_data, last,
    input  ready
  );
  modport sink (
    input  valid, ctrl_out, mask_out, scroll_x, scroll_y,
           entry_valid, entry_addr, entry_data, last,
    output ready
  );
endinterface

// ===== hw/rtl/ppu_register_write_queue.sv =====
// video register shadows with a queued video write memory drained in runs
//
//   channel | dir | transaction
//   --------+-----+----------------------------------------------------
//   req_i   | in  | register write (req_type 0) or frame flush (1)
//   rsp_o   | out | one drained entry, or one empty result on empty flush
//
// a new request is taken whenever the fsm is idle.
// a drain reads the queue memory one entry per cycle while the sink is ready (one
// read port with registered read data): a read state to start, then one load per entry.
// an empty flush waits in its own state for a free output register.
// the output register stalls the drain while rsp_o.ready is low.
// reset clears shadows, toggle, address and count; the memory is not cleared.
module ppu_register_write_queue #(
  parameter int unsigned QUEUE_ENTRIES = ppurwq_pkg::QueueEntriesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ppurwq_req_if.sink        req_i,
  ppurwq_rsp_if.source      rsp_o
);

  localparam int unsigned IdxW = (QUEUE_ENTRIES > 1) ? $clog2(QUEUE_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_ENTRIES + 1);
  localparam int unsigned AW   = ppurwq_pkg::AddrW;
  localparam int unsigned DW   = ppurwq_pkg::DataW;

  ppurwq_pkg::state_e state_q, state_d;

  logic [DW-1:0]   ctrl_q, ctrl_d;
  logic [DW-1:0]   mask_q, mask_d;
  logic [DW-1:0]   scroll_x_q, scroll_x_d;
  logic [DW-1:0]   scroll_y_q, scroll_y_d;
  logic [AW-1:0]   vaddr_q, vaddr_d;
  logic            toggle_q, toggle_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;

  // output register
  logic            out_valid_q, out_valid_d;
  logic [DW-1:0]   out_ctrl_q, out_mask_q, out_sx_q, out_sy_q;
  logic            out_ev_q, out_last_q;
  ppurwq_pkg::entry_t out_entry_q;

  // queue memory
  ppurwq_pkg::entry_t mem [QUEUE_ENTRIES];
  ppurwq_pkg::entry_t rdata_q;
  ppurwq_pkg::entry_t mem_wdata;
  logic               mem_we, mem_re;
  logic [IdxW-1:0]    mem_raddr, mem_waddr;

  logic accept, out_free, drain_last, full_hit, out_load, is_flush;

  assign accept     = req_i.valid && req_i.ready;
  assign is_flush   = (req_i.req_type == ppurwq_pkg::ReqFlush);
  assign out_free   = !out_valid_q || rsp_o.ready;
  assign drain_last = ((CntW'(rd_idx_q) + CntW'(1)) == count_q);
  assign full_hit   = (count_q == CntW'(QUEUE_ENTRIES - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ppurwq_pkg::StIdle: begin
        if (accept) begin
          if (is_flush) begin
            state_d = (count_q == '0) ? ppurwq_pkg::StEmpty : ppurwq_pkg::StRead;
          end else if (req_i.reg_index == ppurwq_pkg::RegData && full_hit) begin
            state_d = ppurwq_pkg::StRead;
          end
        end
      end
      ppurwq_pkg::StRead: state_d = ppurwq_pkg::StLoad;
      ppurwq_pkg::StLoad: begin
        if (out_free && drain_last) state_d = ppurwq_pkg::StIdle;
      end
      ppurwq_pkg::StEmpty: begin
        if (out_free) state_d = ppurwq_pkg::StIdle;
      end
    endcase
  end

  // fsm outputs
  always_comb begin
    req_i.ready = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = rd_idx_q;
    out_load    = 1'b0;
    unique case (state_q)
      ppurwq_pkg::StIdle:  req_i.ready = 1'b1;
      ppurwq_pkg::StRead:  mem_re = 1'b1;
      ppurwq_pkg::StLoad: begin
        if (out_free) begin
          out_load = 1'b1;
          if (!drain_last) begin
            mem_re    = 1'b1;
            mem_raddr = rd_idx_q + IdxW'(1);
          end
        end
      end
      ppurwq_pkg::StEmpty: out_load = out_free;
    endcase
  end

  // register updates and queue writes
  always_comb begin
    ctrl_d     = ctrl_q;
    mask_d     = mask_q;
    scroll_x_d = scroll_x_q;
    scroll_y_d = scroll_y_q;
    vaddr_d    = vaddr_q;
    toggle_d   = toggle_q;
    count_d    = count_q;
    rd_idx_d   = rd_idx_q;
    mem_we     = 1'b0;
    mem_waddr  = count_q[IdxW-1:0];
    mem_wdata  = '{addr: vaddr_q, data: req_i.data_value};

    if (accept) begin
      rd_idx_d = '0;
      if (!is_flush) begin
        unique case (req_i.reg_index)
          ppurwq_pkg::RegCtrl: ctrl_d = req_i.data_value;
          ppurwq_pkg::RegMask: mask_d = req_i.data_value;
          ppurwq_pkg::RegScroll: begin
            if (toggle_q) scroll_y_d = req_i.data_value;
            else          scroll_x_d = req_i.data_value;
            toggle_d = !toggle_q;
          end
          ppurwq_pkg::RegAddr: begin
            if (toggle_q) vaddr_d = {vaddr_q[AW-1:DW], req_i.data_value};
            else          vaddr_d = {req_i.data_value[AW-DW-1:0], vaddr_q[DW-1:0]};
            toggle_d = !toggle_q;
          end
          ppurwq_pkg::RegData: begin
            mem_we  = 1'b1;
            count_d = count_q + CntW'(1);
            vaddr_d = vaddr_q + (ctrl_q[ppurwq_pkg::CtrlIncBit] ?
                                 ppurwq_pkg::AddrIncRow : ppurwq_pkg::AddrIncOne);
          end
          default: ;
        endcase
      end
    end

    if (state_q == ppurwq_pkg::StLoad && out_free) begin
      if (drain_last) count_d  = '0;
      else            rd_idx_d = rd_idx_q + IdxW'(1);
    end
  end

  assign out_valid_d = out_load ? 1'b1 : (rsp_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ppurwq_pkg::StIdle;
      ctrl_q      <= '0;
      mask_q      <= '0;
      scroll_x_q  <= '0;
      scroll_y_q  <= '0;
      vaddr_q     <= '0;
      toggle_q    <= 1'b0;
      count_q     <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ctrl_q      <= ctrl_d;
      mask_q      <= mask_d;
      scroll_x_q  <= scroll_x_d;
      scroll_y_q  <= scroll_y_d;
      vaddr_q     <= vaddr_d;
      toggle_q    <= toggle_d;
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload, snapshot of the shadows at load time
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_ctrl_q <= ctrl_q | ppurwq_pkg::CtrlForceMask;
      out_mask_q <= mask_q;
      out_sx_q   <= scroll_x_q;
      out_sy_q   <= scroll_y_q;
      if (state_q == ppurwq_pkg::StLoad) begin
        out_ev_q    <= 1'b1;
        out_entry_q <= rdata_q;
        out_last_q  <= drain_last;
      end else begin
        out_ev_q    <= 1'b0;
        out_entry_q <= '0;
        out_last_q  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.ctrl_out    = out_ctrl_q;
  assign rsp_o.mask_out    = out_mask_q;
  assign rsp_o.scroll_x    = out_sx_q;
  assign rsp_o.scroll_y    = out_sy_q;
  assign rsp_o.entry_valid = out_ev_q;
  assign rsp_o.entry_addr  = out_entry_q.addr;
  assign rsp_o.entry_data  = out_entry_q.data;
  assign rsp_o.last        = out_last_q;

  // queue never holds a full count between requests
  a_count_below_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ppurwq_pkg::StIdle |-> count_q < CntW'(QUEUE_ENTRIES))
    else $error("queue count reached full while idle");

  // flush of an empty queue gives the empty result path
  a_empty_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_flush && count_q == '0 |=> state_q == ppurwq_pkg::StEmpty)
    else $error("empty flush did not take the empty result path");

  // an empty result is always the final one
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.entry_valid |-> rsp_o.last)
    else $error("empty result without last mark");

  // the last entry of a drain leaves the queue empty
  a_drain_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ppurwq_pkg::StLoad && out_free && drain_last |=> count_q == '0)
    else $error("drain did not clear the queue count");

endmodule
